// ===== rtl/core/rbt_pkg.sv =====
package rbt_pkg;

   localparam int TIME_BITS_DEF = 16;
   localparam int TAN_DEPTH_DEF = 256;

   localparam int ANGLE_FULL  = 46080;
   localparam int DIST_MAX    = 16777215;
   localparam int STALL_TOPUP = 6;

   localparam logic [7:0]  DETECT_LIMIT_RST = 8'd10;
   localparam logic [7:0]  MOTOR_LIMIT_RST  = 8'd10;
   localparam logic [15:0] RATIO_RST        = 16'd256;

   localparam int COT_W = 48;
   localparam logic [COT_W-1:0] COT_HUGE = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      CMD_INDEX = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DETECT_LIMIT = 2'd0,
      CSR_MOTOR_LIMIT  = 2'd1,
      CSR_ANGLE_OFFSET = 2'd2,
      CSR_RATIO        = 2'd3
   } csr_type;

   localparam longint CORDIC_ATAN [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   function automatic longint shift_signed(longint v, int s);
      if (v >= 0) begin
         return v >>> s;
      end
      return -((-v) >>> s);
   endfunction

   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // cotangent of r steps of 90/2^ld degrees, Q32, built by integer CORDIC
   function automatic logic [COT_W-1:0] cot_entry(int r, int ld);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      logic [63:0] c;
      if (r == 0) begin
         return COT_HUGE;
      end
      x = longint'(1) <<< 30;
      y = 0;
      z = longint'(r) <<< (30 - ld);
      for (int i = 0; i < 32; i++) begin
         dx = shift_signed(y, i);
         dy = shift_signed(x, i);
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - CORDIC_ATAN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + CORDIC_ATAN[i];
         end
      end
      if (y <= 0) begin
         return COT_HUGE;
      end
      if (x <= 0) begin
         return '0;
      end
      c = udiv64(64'(x) << 32, 64'(y));
      if (c > 64'(COT_HUGE)) begin
         return COT_HUGE;
      end
      return c[COT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/rotating_beacon_tracker_core.sv =====
// Index pulses, edges, unused commands and ticks without long work: result in the cycle after
// accept. A tick with a new sighting and a nonzero period runs one shared bit-serial divider
// of D = max(TIME_BITS+16, 28) bits up to three times, twice when the distance sum is not
// positive, and a bit-serial multiplier over the 16 ratio bits.
// One word is in work at a time; the next is taken once the result slot frees.
// Synchronous active-high reset restores all but the datapath registers; no clearing pass.
module rotating_beacon_tracker_core #(
   parameter int TIME_BITS       = rbt_pkg::TIME_BITS_DEF,
   parameter int TAN_TABLE_DEPTH = rbt_pkg::TAN_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // timestamp[15:0], motor_powered[16], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // robot_present[0], angle_deg[16:1],
                                    // distance_cm[40:17], fresh_sighting[41],
                                    // restart_motor[42], zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [16:0] csr_wdata
);

   localparam int TW = TIME_BITS;
   localparam int LD = $clog2(TAN_TABLE_DEPTH);
   localparam int DW = (TW + 16 > 28) ? TW + 16 : 28;
   localparam int CW = $clog2(DW + 1);
   localparam int AW = TW + 18;
   localparam int CT = rbt_pkg::COT_W;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DIV_ANG  = 9'b000000010,
      ST_ANG      = 9'b000000100,
      ST_DIV_HALF = 9'b000001000,
      ST_COT      = 9'b000010000,
      ST_MUL      = 9'b000100000,
      ST_SUM      = 9'b001000000,
      ST_DIV_TEN  = 9'b010000000,
      ST_DIST     = 9'b100000000
   } state_type;

   logic [CT-1:0] cot_rom [TAN_TABLE_DEPTH];

   for (genvar g = 0; g < TAN_TABLE_DEPTH; g++) begin : g_cot
      assign cot_rom[g] = rbt_pkg::cot_entry(g, LD);
   end

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [7:0]  detect_limit_ff, detect_limit_in;
   logic [7:0]  motor_limit_ff, motor_limit_in;
   logic [16:0] offset_ff, offset_in;
   logic [15:0] ratio_ff, ratio_in;

   logic [TW-1:0] last_index_ff, last_index_in;
   logic [TW-1:0] period_ff, period_in;
   logic [TW-1:0] pend_begin_ff, pend_begin_in;
   logic [TW-1:0] lat_begin_ff, lat_begin_in;
   logic [TW-1:0] lat_end_ff, lat_end_in;
   logic awaiting_ff, awaiting_in;
   logic sighting_ff, sighting_in;
   logic present_ff, present_in;
   logic [15:0] angle_ff, angle_in;
   logic [23:0] dist_ff, dist_in;
   logic [7:0]  lost_ff, lost_in;
   logic [7:0]  stall_ff, stall_in;
   logic fresh_ff, fresh_in;
   logic restart_ff, restart_in;

   logic [TW-1:0] div_den_ff, div_den_in;
   logic [TW-1:0] div_rem_ff, div_rem_in;
   logic [DW-1:0] div_quo_ff, div_quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] width_ff, width_in;
   logic [CT-1:0] cot_ff, cot_in;
   logic [63:0]   acc_ff, acc_in;
   logic [15:0]   mul_sr_ff, mul_sr_in;
   logic vmax_ff, vmax_in;
   logic vzero_ff, vzero_in;
   logic vneg_ff, vneg_in;

   logic          accept;
   rbt_pkg::cmd_type cmd;
   logic [TW-1:0] ts;
   logic [TW-1:0] t_rel;
   logic [TW-1:0] w_now;
   logic [TW-1:0] c_now;
   logic [TW:0]   div_sh;
   logic [TW:0]   div_diff;
   logic          div_ge;
   logic          div_last;
   logic [TW+15:0] quot;
   logic signed [AW-1:0] a_raw;
   logic signed [AW-1:0] a_wrap;
   logic [LD:0]   r_val;
   logic [LD:0]   r_mirror;
   logic [LD-1:0] cot_idx;
   logic [30:0]   m_val;
   logic [23:0]   mag;
   logic signed [29:0] v_val;
   logic [27:0]   dist9;
   logic signed [29:0] sum;
   logic [27:0]   d_val;

   assign cmd        = rbt_pkg::cmd_type'(req_tuser);
   assign ts         = TW'(req_tdata[15:0]);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign t_rel      = ts - last_index_ff;
   assign w_now      = lat_end_ff - lat_begin_ff;
   assign c_now      = lat_begin_ff + (w_now >> 1);

   assign div_sh   = {div_rem_ff, div_quo_ff[DW-1]};
   assign div_diff = div_sh - {1'b0, div_den_ff};
   assign div_ge   = div_sh >= {1'b0, div_den_ff};
   assign div_last = cnt_ff == CW'(DW - 1);

   assign quot   = div_quo_ff[TW+15:0];
   assign a_raw  = $signed(AW'(quot)) + $signed({{(AW-17){offset_ff[16]}}, offset_ff});
   assign r_val  = div_quo_ff[LD:0];
   assign r_mirror = (LD+1)'(2 * TAN_TABLE_DEPTH) - r_val;
   assign cot_idx  = r_val[LD] ? r_mirror[LD-1:0] : r_val[LD-1:0];
   assign m_val  = acc_ff[63:33];
   assign mag    = (m_val > 31'(rbt_pkg::DIST_MAX)) ? 24'(rbt_pkg::DIST_MAX) : m_val[23:0];
   assign dist9  = {1'b0, dist_ff, 3'b000} + {4'b0000, dist_ff};
   assign sum    = v_val + $signed({2'b00, dist9});
   assign d_val  = div_quo_ff[27:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, restart_ff, fresh_ff, dist_ff, angle_ff, present_ff};

   always_comb begin
      if (a_raw > $signed(AW'(rbt_pkg::ANGLE_FULL))) begin
         a_wrap = a_raw - $signed(AW'(rbt_pkg::ANGLE_FULL));
      end else if (a_raw < 0) begin
         a_wrap = a_raw + $signed(AW'(rbt_pkg::ANGLE_FULL));
      end else begin
         a_wrap = a_raw;
      end
      if (vmax_ff) begin
         v_val = 30'(rbt_pkg::DIST_MAX);
      end else if (vzero_ff) begin
         v_val = '0;
      end else if (vneg_ff) begin
         v_val = -$signed({6'b000000, mag});
      end else begin
         v_val = $signed({6'b000000, mag});
      end
   end

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      detect_limit_in = detect_limit_ff;
      motor_limit_in  = motor_limit_ff;
      offset_in       = offset_ff;
      ratio_in        = ratio_ff;
      last_index_in   = last_index_ff;
      period_in       = period_ff;
      pend_begin_in   = pend_begin_ff;
      lat_begin_in    = lat_begin_ff;
      lat_end_in      = lat_end_ff;
      awaiting_in     = awaiting_ff;
      sighting_in     = sighting_ff;
      present_in      = present_ff;
      angle_in        = angle_ff;
      dist_in         = dist_ff;
      lost_in         = lost_ff;
      stall_in        = stall_ff;
      fresh_in        = fresh_ff;
      restart_in      = restart_ff;
      div_den_in      = div_den_ff;
      div_rem_in      = div_rem_ff;
      div_quo_in      = div_quo_ff;
      cnt_in          = cnt_ff;
      width_in        = width_ff;
      cot_in          = cot_ff;
      acc_in          = acc_ff;
      mul_sr_in       = mul_sr_ff;
      vmax_in         = vmax_ff;
      vzero_in        = vzero_ff;
      vneg_in         = vneg_ff;

      if (csr_we) begin
         unique case (rbt_pkg::csr_type'(csr_addr))
            rbt_pkg::CSR_DETECT_LIMIT: detect_limit_in = csr_wdata[7:0];
            rbt_pkg::CSR_MOTOR_LIMIT:  motor_limit_in  = csr_wdata[7:0];
            rbt_pkg::CSR_ANGLE_OFFSET: offset_in       = csr_wdata;
            rbt_pkg::CSR_RATIO:        ratio_in        = csr_wdata[15:0];
            default:                   offset_in       = offset_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fresh_in     = 1'b0;
               restart_in   = 1'b0;
               rsp_valid_in = 1'b1;
               unique case (cmd)
                  rbt_pkg::CMD_INDEX: begin
                     period_in     = t_rel;
                     last_index_in = ts;
                     pend_begin_in = '1;
                     if (stall_ff <= 8'(rbt_pkg::STALL_TOPUP)) begin
                        stall_in = stall_ff + motor_limit_ff;
                     end
                  end
                  rbt_pkg::CMD_EDGE: begin
                     if (!awaiting_ff) begin
                        pend_begin_in = t_rel;
                        awaiting_in   = 1'b1;
                     end else begin
                        lat_begin_in = pend_begin_ff;
                        lat_end_in   = t_rel;
                        sighting_in  = 1'b1;
                        awaiting_in  = 1'b0;
                     end
                  end
                  rbt_pkg::CMD_TICK: begin
                     if (sighting_ff) begin
                        present_in  = 1'b1;
                        sighting_in = 1'b0;
                        lost_in     = '0;
                        fresh_in    = 1'b1;
                        if (period_ff != '0) begin
                           rsp_valid_in = 1'b0;
                           width_in     = w_now;
                           div_den_in   = period_ff;
                           div_rem_in   = '0;
                           div_quo_in   = (DW'(c_now) << 15) + (DW'(c_now) << 13)
                                        + (DW'(c_now) << 12) + (DW'(c_now) << 10);
                           cnt_in       = '0;
                           state_in     = ST_DIV_ANG;
                        end
                     end else if (lost_ff >= detect_limit_ff) begin
                        present_in = 1'b0;
                     end else begin
                        lost_in = lost_ff + 8'd1;
                     end
                     if (stall_ff == '0 && req_tdata[16]) begin
                        restart_in = 1'b1;
                        stall_in   = motor_limit_ff;
                     end else begin
                        stall_in = stall_ff - 8'd1;
                     end
                  end
                  rbt_pkg::CMD_NONE: begin
                     fresh_in = 1'b0;
                  end
                  default: begin
                     fresh_in = 1'b0;
                  end
               endcase
            end
         end
         ST_DIV_ANG, ST_DIV_HALF, ST_DIV_TEN: begin
            div_rem_in = div_ge ? div_diff[TW-1:0] : div_sh[TW-1:0];
            div_quo_in = {div_quo_ff[DW-2:0], div_ge};
            cnt_in     = cnt_ff + CW'(1);
            if (div_last) begin
               priority if (state_ff == ST_DIV_ANG) begin
                  state_in = ST_ANG;
               end else if (state_ff == ST_DIV_HALF) begin
                  state_in = ST_COT;
               end else begin
                  state_in = ST_DIST;
               end
            end
         end
         ST_ANG: begin
            if (a_wrap < 0) begin
               angle_in = '0;
            end else if (a_wrap > $signed(AW'(rbt_pkg::ANGLE_FULL))) begin
               angle_in = 16'(rbt_pkg::ANGLE_FULL);
            end else begin
               angle_in = a_wrap[15:0];
            end
            div_quo_in = DW'(width_ff) << (LD + 1);
            div_rem_in = '0;
            cnt_in     = '0;
            state_in   = ST_DIV_HALF;
         end
         ST_COT: begin
            vmax_in   = r_val == '0;
            vzero_in  = r_val == (LD+1)'(TAN_TABLE_DEPTH);
            vneg_in   = r_val[LD];
            cot_in    = cot_rom[cot_idx];
            acc_in    = '0;
            mul_sr_in = ratio_ff;
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            acc_in    = {acc_ff[62:0], 1'b0} + (mul_sr_ff[15] ? 64'(cot_ff) : 64'd0);
            mul_sr_in = {mul_sr_ff[14:0], 1'b0};
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(15)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum <= 0) begin
               dist_in      = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               div_quo_in = DW'(sum[27:0] + 28'd5);
               div_den_in = TW'(10);
               div_rem_in = '0;
               cnt_in     = '0;
               state_in   = ST_DIV_TEN;
            end
         end
         ST_DIST: begin
            dist_in      = (d_val > 28'(rbt_pkg::DIST_MAX)) ? 24'(rbt_pkg::DIST_MAX)
                                                            : d_val[23:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         detect_limit_ff <= rbt_pkg::DETECT_LIMIT_RST;
         motor_limit_ff  <= rbt_pkg::MOTOR_LIMIT_RST;
         offset_ff       <= '0;
         ratio_ff        <= rbt_pkg::RATIO_RST;
         last_index_ff   <= '0;
         period_ff       <= '0;
         pend_begin_ff   <= '1;
         lat_begin_ff    <= '0;
         lat_end_ff      <= '0;
         awaiting_ff     <= 1'b0;
         sighting_ff     <= 1'b0;
         present_ff      <= 1'b0;
         angle_ff        <= '0;
         dist_ff         <= '0;
         lost_ff         <= '0;
         stall_ff        <= rbt_pkg::MOTOR_LIMIT_RST;
         fresh_ff        <= 1'b0;
         restart_ff      <= 1'b0;
         cnt_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         detect_limit_ff <= detect_limit_in;
         motor_limit_ff  <= motor_limit_in;
         offset_ff       <= offset_in;
         ratio_ff        <= ratio_in;
         last_index_ff   <= last_index_in;
         period_ff       <= period_in;
         pend_begin_ff   <= pend_begin_in;
         lat_begin_ff    <= lat_begin_in;
         lat_end_ff      <= lat_end_in;
         awaiting_ff     <= awaiting_in;
         sighting_ff     <= sighting_in;
         present_ff      <= present_in;
         angle_ff        <= angle_in;
         dist_ff         <= dist_in;
         lost_ff         <= lost_in;
         stall_ff        <= stall_in;
         fresh_ff        <= fresh_in;
         restart_ff      <= restart_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      width_ff   <= width_in;
      cot_ff     <= cot_in;
      acc_ff     <= acc_in;
      mul_sr_ff  <= mul_sr_in;
      vmax_ff    <= vmax_in;
      vzero_ff   <= vzero_in;
      vneg_ff    <= vneg_in;
   end

endmodule

// ===== test/rotating_beacon_tracker_checker.sv =====
module rotating_beacon_tracker_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // timestamp[15:0], motor_powered[16], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // robot_present[0], angle_deg[16:1],
                                    // distance_cm[40:17], fresh_sighting[41],
                                    // restart_motor[42], zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [16:0] csr_wdata,
   output int          pending,
   output int          errors
);

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic        present;
      logic [15:0] angle;
      logic [23:0] distance;
      logic        fresh;
      logic        restart;
   } status_type;

   localparam longint ATAN_Q30 [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   status_type  status_q[$];
   logic [47:0] cot_q32 [256];

   logic [7:0]  lim_detect, lim_motor;
   logic [16:0] offset_q7;
   logic [15:0] ratio_q8;
   logic [15:0] idx_time, period, open_begin, seen_begin, seen_end;
   logic        in_object, have_sighting, present;
   logic [15:0] angle;
   logic [23:0] distance;
   logic [7:0]  lost_cnt, stall_cnt;

   function automatic longint asr(longint v, int s);
      if (v >= 0) begin
         return v >>> s;
      end
      return -((-v) >>> s);
   endfunction

   function automatic logic [47:0] cordic_cot(int r);
      longint x, y, z, dx, dy;
      u64_type c;
      x = longint'(1) <<< 30;
      y = 0;
      z = (longint'(r) <<< 30) / 256;
      for (int i = 0; i < 32; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
         end
      end
      if (y <= 0) return rbt_pkg::COT_HUGE;
      if (x <= 0) return '0;
      c = (u64_type'(x) << 32) / u64_type'(y);
      return (c > u64_type'(rbt_pkg::COT_HUGE)) ? rbt_pkg::COT_HUGE : c[47:0];
   endfunction

   initial begin
      cot_q32[0] = rbt_pkg::COT_HUGE;
      for (int r = 1; r < 256; r++) cot_q32[r] = cordic_cot(r);
   end

   function automatic longint half_cot(int r);
      u64_type m;
      m = (u64_type'(ratio_q8) * u64_type'(cot_q32[r])) >> 33;
      return (m > rbt_pkg::DIST_MAX) ? longint'(rbt_pkg::DIST_MAX) : longint'(m);
   endfunction

   task automatic take_sighting();
      logic [15:0] w, c;
      longint a, v, sum, d;
      int r;
      w = seen_end - seen_begin;
      c = seen_begin + (w >> 1);
      if (period != 0) begin
         a = longint'(longint'(c) * rbt_pkg::ANGLE_FULL / longint'(period))
            + longint'($signed(offset_q7));
         r = int'((longint'(w) * 512 / longint'(period)) % 512);
         if (a > rbt_pkg::ANGLE_FULL) a -= rbt_pkg::ANGLE_FULL;
         else if (a < 0) a += rbt_pkg::ANGLE_FULL;
         if (a < 0) a = 0;
         if (a > rbt_pkg::ANGLE_FULL) a = rbt_pkg::ANGLE_FULL;
         angle = a[15:0];
         if (r == 0) v = rbt_pkg::DIST_MAX;
         else if (r == 256) v = 0;
         else if (r < 256) v = half_cot(r);
         else v = -half_cot(512 - r);
         sum = v + 9 * longint'(distance);
         if (sum <= 0) begin
            distance = '0;
         end else begin
            d = (sum + 5) / 10;
            distance = (d > rbt_pkg::DIST_MAX) ? 24'(rbt_pkg::DIST_MAX) : d[23:0];
         end
      end
      present = 1'b1;
      have_sighting = 1'b0;
      lost_cnt = '0;
   endtask

   task automatic track_event(rbt_pkg::cmd_type cmd, logic [15:0] ts, logic powered);
      status_type s;
      logic [15:0] t;
      s = '0;
      t = ts - idx_time;
      case (cmd)
         rbt_pkg::CMD_INDEX: begin
            period = t;
            idx_time = ts;
            open_begin = 16'hFFFF;
            if (stall_cnt <= rbt_pkg::STALL_TOPUP) stall_cnt = stall_cnt + lim_motor;
         end
         rbt_pkg::CMD_EDGE: begin
            if (!in_object) begin
               open_begin = t;
               in_object = 1'b1;
            end else begin
               seen_begin = open_begin;
               seen_end = t;
               have_sighting = 1'b1;
               in_object = 1'b0;
            end
         end
         rbt_pkg::CMD_TICK: begin
            if (have_sighting) begin
               take_sighting();
               s.fresh = 1'b1;
            end else if (lost_cnt >= lim_detect) begin
               present = 1'b0;
            end else begin
               lost_cnt++;
            end
            if (stall_cnt == 0 && powered) begin
               s.restart = 1'b1;
               stall_cnt = lim_motor;
            end else begin
               stall_cnt = stall_cnt - 8'd1;
            end
         end
         default: ;
      endcase
      s.present = present;
      s.angle = angle;
      s.distance = distance;
      status_q.push_back(s);
   endtask

   task automatic report_mismatch(string what, longint want, longint got);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      status_type want;
      if (reset) begin
         errors = 0;
         status_q.delete();
         lim_detect = rbt_pkg::DETECT_LIMIT_RST;
         lim_motor = rbt_pkg::MOTOR_LIMIT_RST;
         offset_q7 = '0;
         ratio_q8 = rbt_pkg::RATIO_RST;
         idx_time = '0; period = '0; open_begin = 16'hFFFF;
         seen_begin = '0; seen_end = '0;
         in_object = 1'b0; have_sighting = 1'b0; present = 1'b0;
         angle = '0; distance = '0; lost_cnt = '0; stall_cnt = rbt_pkg::MOTOR_LIMIT_RST;
      end else begin
         if (csr_we) begin
            case (rbt_pkg::csr_type'(csr_addr))
               rbt_pkg::CSR_DETECT_LIMIT: lim_detect = csr_wdata[7:0];
               rbt_pkg::CSR_MOTOR_LIMIT:  lim_motor = csr_wdata[7:0];
               rbt_pkg::CSR_ANGLE_OFFSET: offset_q7 = csr_wdata;
               rbt_pkg::CSR_RATIO:        ratio_q8 = csr_wdata[15:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               report_mismatch("unexpected word", 0, 1);
            end else begin
               want = status_q.pop_front();
               if (rsp_tdata[0] !== want.present)
                  report_mismatch("robot_present", want.present, rsp_tdata[0]);
               if (rsp_tdata[16:1] !== want.angle)
                  report_mismatch("angle_deg", want.angle, rsp_tdata[16:1]);
               if (rsp_tdata[40:17] !== want.distance)
                  report_mismatch("distance_cm", want.distance, rsp_tdata[40:17]);
               if (rsp_tdata[41] !== want.fresh)
                  report_mismatch("fresh_sighting", want.fresh, rsp_tdata[41]);
               if (rsp_tdata[42] !== want.restart)
                  report_mismatch("restart_motor", want.restart, rsp_tdata[42]);
            end
         end
         if (req_tvalid && req_tready)
            track_event(rbt_pkg::cmd_type'(req_tuser), req_tdata[15:0], req_tdata[16]);
      end
      pending = status_q.size();
   end
endmodule

// ===== test/testbench.sv =====
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // timestamp[15:0], motor_powered[16], zero pad
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // robot_present[0], angle_deg[16:1],
                                  // distance_cm[40:17], fresh_sighting[41],
                                  // restart_motor[42], zero pad
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [16:0] csr_wdata = '0;
   int          pending, errors;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   int          sent = 0;
   logic        hold_rsp = 1'b0;
   logic [15:0] clock_base = '0;
   longint      cycles = 0;

   always #4 clock = ~clock;

   rotating_beacon_tracker_core dut (.*);
   rotating_beacon_tracker_checker chk (.*);

   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic post_event(rbt_pkg::cmd_type cmd, logic [15:0] ts, logic powered);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, powered, ts};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic set_registers(logic [7:0] det, logic [7:0] mot, int offs, logic [15:0] ratio);
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= rbt_pkg::CSR_DETECT_LIMIT; csr_wdata <= {9'd0, det};
      @(posedge clock);
      csr_addr <= rbt_pkg::CSR_MOTOR_LIMIT; csr_wdata <= {9'd0, mot};
      @(posedge clock);
      csr_addr <= rbt_pkg::CSR_ANGLE_OFFSET; csr_wdata <= offs[16:0];
      @(posedge clock);
      csr_addr <= rbt_pkg::CSR_RATIO; csr_wdata <= ratio;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one mirror revolution: index pulse, one or two object edge pairs starting inside it, one to three ticks each
   task automatic revolution();
      int span, b, w, n;
      span = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(100, 60000);
      clock_base = clock_base + span[15:0];
      post_event(rbt_pkg::CMD_INDEX, clock_base, 1'($urandom_range(1)));
      n = $urandom_range(1, 2);
      for (int k = 0; k < n; k++) begin
         b = $urandom_range(span - 1);
         w = $urandom_range(span);
         post_event(rbt_pkg::CMD_EDGE, clock_base + b[15:0], 1'($urandom_range(1)));
         post_event(rbt_pkg::CMD_EDGE, clock_base + b[15:0] + w[15:0],
                    1'($urandom_range(1)));
         repeat ($urandom_range(1, 3))
            post_event(rbt_pkg::CMD_TICK, 16'($urandom), 1'($urandom_range(1)));
      end
   endtask

   task automatic random_part(int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         if ($urandom_range(99) < 15)
            post_event(rbt_pkg::cmd_type'($urandom_range(3)), 16'($urandom),
                       1'($urandom_range(1)));
         else
            revolution();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero period sighting, ticks, extremes and unused command
      post_event(rbt_pkg::CMD_EDGE, 16'h0000, 1'b0);
      post_event(rbt_pkg::CMD_EDGE, 16'hFFFF, 1'b1);
      post_event(rbt_pkg::CMD_TICK, 16'h0000, 1'b1);
      post_event(rbt_pkg::CMD_NONE, 16'hFFFF, 1'b1);
      post_event(rbt_pkg::CMD_INDEX, 16'd1000, 1'b0);
      post_event(rbt_pkg::CMD_INDEX, 16'd2000, 1'b0);
      post_event(rbt_pkg::CMD_EDGE, 16'd2100, 1'b0);
      post_event(rbt_pkg::CMD_EDGE, 16'd2100, 1'b0);
      post_event(rbt_pkg::CMD_TICK, 16'd0, 1'b0);
      post_event(rbt_pkg::CMD_EDGE, 16'd2100, 1'b0);
      post_event(rbt_pkg::CMD_EDGE, 16'd2600, 1'b0);
      post_event(rbt_pkg::CMD_TICK, 16'd0, 1'b1);
      post_event(rbt_pkg::CMD_EDGE, 16'd2050, 1'b0);
      post_event(rbt_pkg::CMD_EDGE, 16'd2900, 1'b0);
      post_event(rbt_pkg::CMD_TICK, 16'd0, 1'b1);
      repeat (10) post_event(rbt_pkg::CMD_TICK, 16'hFFFF, 1'b1);

      set_registers(8'd0, 8'd0, -46080, 16'hFFFF);
      clock_base = 16'hFF00;
      send_idle_pct = 33; recv_stall_pct = 77;
      random_part(300);

      fork
         random_part(200);
         begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join

      set_registers(8'd255, 8'd255, 46080, 16'd0);
      send_idle_pct = 77; recv_stall_pct = 33;
      random_part(450);

      set_registers(8'd3, 8'd5, -65536, 16'd700);
      random_part(200);

      set_registers(8'd10, 8'd10, 65535, 16'd256);
      send_idle_pct = 0; recv_stall_pct = 0;
      random_part(400);

      set_registers(8'd1, 8'd2, 12345, 16'd40000);
      random_part(350);

      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/rbt_pkg.sv
rtl/core/rotating_beacon_tracker_core.sv
test/rotating_beacon_tracker_checker.sv
test/testbench.sv
